// ===== rtl/l2sr_pkg.sv =====
// Package for the L2CAP signaling responder: transaction types, command,
// packet-kind and outcome codes, fixed CIDs and handshake flag bits.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package l2sr_pkg;

  // Input transaction: one parsed signaling command
  typedef struct packed {
    logic [7:0]  sig_code;
    logic [7:0]  sig_ident;
    logic [9:0]  payload_len;
    logic [15:0] word_zero;
    logic [15:0] word_one;
    logic [15:0] word_two;
  } l2sr_in_t;

  // Output transaction: one emitted packet or status record
  typedef struct packed {
    logic [1:0]  packet_kind;
    logic [7:0]  out_ident;
    logic [15:0] dest_cid;
    logic [15:0] source_cid;
    logic [2:0]  outcome;
    logic        both_open;
    logic        last;
  } l2sr_out_t;

  // Handoff from the command engine to the result buffer
  typedef struct packed {
    logic load;
    logic two;
  } l2sr_ctl_t;

  // Configuration register indexes
  localparam logic [1:0] REG_ACL_HANDLE    = 2'd0;
  localparam logic [1:0] REG_CONTROL_PSM   = 2'd1;
  localparam logic [1:0] REG_INTERRUPT_PSM = 2'd2;
  localparam logic [1:0] REG_LOCAL_MTU     = 2'd3;

  localparam logic [15:0] CONTROL_PSM_RST   = 16'd17;
  localparam logic [15:0] INTERRUPT_PSM_RST = 16'd19;

  // Signaling command codes
  localparam logic [7:0] CODE_CONN_REQ = 8'd2;
  localparam logic [7:0] CODE_CONF_REQ = 8'd4;
  localparam logic [7:0] CODE_CONF_RSP = 8'd5;

  // Packet kinds
  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_CONN_RSP = 2'd1;
  localparam logic [1:0] KIND_CONF_REQ = 2'd2;
  localparam logic [1:0] KIND_CONF_RSP = 2'd3;

  // Outcome codes
  localparam logic [2:0] OUT_HANDLED     = 3'd0;
  localparam logic [2:0] OUT_TOO_SHORT   = 3'd1;
  localparam logic [2:0] OUT_UNKNOWN_PSM = 3'd2;
  localparam logic [2:0] OUT_UNKNOWN_CID = 3'd3;
  localparam logic [2:0] OUT_UNHANDLED   = 3'd4;

  // Fixed local CIDs and the SDP PSM
  localparam logic [15:0] CID_SDP  = 16'h003F;
  localparam logic [15:0] CID_CTRL = 16'h0040;
  localparam logic [15:0] CID_INTR = 16'h0041;
  localparam logic [15:0] SDP_PSM  = 16'h0001;

  // Minimum payload lengths
  localparam logic [9:0] LEN_HDR      = 10'd4;
  localparam logic [9:0] LEN_REQ_MIN  = 10'd8;
  localparam logic [9:0] LEN_RSP_MIN  = 10'd10;

  // Handshake flag bits
  localparam int HS_CONN_RSP  = 0;
  localparam int HS_REQ_SENT  = 1;
  localparam int HS_THEIR_ACK = 2;
  localparam int HS_OUR_ACK   = 3;

  localparam int NUM_CH = 3;

  function automatic logic [15:0] chan_cid(input logic [1:0] ch);
    logic [15:0] cid;
    case (ch)
      2'd0:    cid = CID_SDP;
      2'd1:    cid = CID_CTRL;
      default: cid = CID_INTR;
    endcase
    return cid;
  endfunction

  function automatic logic is_open(input logic [3:0] flags);
    return flags[HS_CONN_RSP] & flags[HS_THEIR_ACK] & flags[HS_OUR_ACK];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/l2cap_signaling_responder_core.sv =====
// L2CAP signaling responder. Input passes the input register, then the
// result register; a connection request's configuration request follows once
// its connection response is taken. Throughput: one command per cycle while
// out_ready holds; a connection request blocks new commands until both its
// results leave (one output port, one result per cycle). Synchronous active-low
// reset clears channel state, the ident counter and both handshake stages.
`timescale 1ns / 1ps
`default_nettype none

module l2cap_signaling_responder_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire l2sr_pkg::l2sr_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output l2sr_pkg::l2sr_out_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [15:0]        cfg_wdata
);

  logic                in_valid_r;
  l2sr_pkg::l2sr_in_t  in_item_r;
  logic [15:0]         control_psm_r;
  logic [15:0]         interrupt_psm_r;
  logic                free;
  logic                advance;
  l2sr_pkg::l2sr_out_t res0;
  l2sr_pkg::l2sr_out_t res1;
  logic                two;
  l2sr_pkg::l2sr_ctl_t ctl;

  // Configuration; link handle and MTU feed no result field and are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_psm_r   <= l2sr_pkg::CONTROL_PSM_RST;
      interrupt_psm_r <= l2sr_pkg::INTERRUPT_PSM_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        l2sr_pkg::REG_CONTROL_PSM:   control_psm_r   <= cfg_wdata;
        l2sr_pkg::REG_INTERRUPT_PSM: interrupt_psm_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  assign advance  = in_valid_r && free;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  l2sr_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (advance),
    .item          (in_item_r),
    .control_psm   (control_psm_r),
    .interrupt_psm (interrupt_psm_r),
    .res0          (res0),
    .res1          (res1),
    .two           (two)
  );

  assign ctl.load = advance;
  assign ctl.two  = two;

  l2sr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res0      (res0),
    .res1      (res1),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/l2sr_engine.sv =====
// Command engine: per-channel remote CID and handshake flags, transmit
// ident counter, and the single-pass decode that forms up to two results.
// Depends on l2sr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module l2sr_engine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire l2sr_pkg::l2sr_in_t item,
  input  wire logic [15:0]        control_psm,
  input  wire logic [15:0]        interrupt_psm,
  output l2sr_pkg::l2sr_out_t     res0,
  output l2sr_pkg::l2sr_out_t     res1,
  output logic                    two
);

  logic [15:0] rcid_r  [l2sr_pkg::NUM_CH];
  logic [15:0] rcid_nxt[l2sr_pkg::NUM_CH];
  logic [3:0]  flags_r  [l2sr_pkg::NUM_CH];
  logic [3:0]  flags_nxt[l2sr_pkg::NUM_CH];
  logic [7:0]  ident_r;
  logic [7:0]  ident_nxt;
  logic [7:0]  ident_inc;

  logic        psm_hit;
  logic [1:0]  psm_ch;
  logic        cid_hit;
  logic [1:0]  cid_ch;
  logic        open_nxt;

  // Channel lookup: SDP wins, then control, then interrupt
  always_comb begin
    psm_hit = 1'b1;
    psm_ch  = 2'd0;
    if (item.word_zero == l2sr_pkg::SDP_PSM) begin
      psm_ch = 2'd0;
    end else if (item.word_zero == control_psm) begin
      psm_ch = 2'd1;
    end else if (item.word_zero == interrupt_psm) begin
      psm_ch = 2'd2;
    end else begin
      psm_hit = 1'b0;
    end

    cid_hit = 1'b1;
    cid_ch  = 2'd0;
    if (item.word_zero == l2sr_pkg::CID_SDP) begin
      cid_ch = 2'd0;
    end else if (item.word_zero == l2sr_pkg::CID_CTRL) begin
      cid_ch = 2'd1;
    end else if (item.word_zero == l2sr_pkg::CID_INTR) begin
      cid_ch = 2'd2;
    end else begin
      cid_hit = 1'b0;
    end
  end

  // Counter pre-increments and skips zero
  always_comb begin
    ident_inc = ident_r + 8'd1;
    if (ident_inc == 8'd0) begin
      ident_inc = 8'd1;
    end
  end

  // Command decode and state update
  always_comb begin
    rcid_nxt  = rcid_r;
    flags_nxt = flags_r;
    ident_nxt = ident_r;
    res0      = '0;
    res1      = '0;
    two       = 1'b0;

    if (item.payload_len < l2sr_pkg::LEN_HDR) begin
      res0.outcome = l2sr_pkg::OUT_TOO_SHORT;
    end else begin
      case (item.sig_code)
        l2sr_pkg::CODE_CONN_REQ: begin
          if (item.payload_len < l2sr_pkg::LEN_REQ_MIN) begin
            res0.outcome = l2sr_pkg::OUT_TOO_SHORT;
          end else if (!psm_hit) begin
            res0.outcome = l2sr_pkg::OUT_UNKNOWN_PSM;
          end else begin
            rcid_nxt[psm_ch] = item.word_one;
            flags_nxt[psm_ch][l2sr_pkg::HS_CONN_RSP] = 1'b1;
            flags_nxt[psm_ch][l2sr_pkg::HS_REQ_SENT] = 1'b1;
            ident_nxt = ident_inc;
            res0.packet_kind = l2sr_pkg::KIND_CONN_RSP;
            res0.out_ident   = item.sig_ident;
            res0.dest_cid    = l2sr_pkg::chan_cid(psm_ch);
            res0.source_cid  = item.word_one;
            res1.packet_kind = l2sr_pkg::KIND_CONF_REQ;
            res1.out_ident   = ident_inc;
            res1.dest_cid    = item.word_one;
            two = 1'b1;
          end
        end
        l2sr_pkg::CODE_CONF_REQ: begin
          if (item.payload_len < l2sr_pkg::LEN_REQ_MIN) begin
            res0.outcome = l2sr_pkg::OUT_TOO_SHORT;
          end else if (!cid_hit) begin
            res0.outcome = l2sr_pkg::OUT_UNKNOWN_CID;
          end else begin
            flags_nxt[cid_ch][l2sr_pkg::HS_THEIR_ACK] = 1'b1;
            res0.packet_kind = l2sr_pkg::KIND_CONF_RSP;
            res0.out_ident   = item.sig_ident;
            res0.dest_cid    = rcid_r[cid_ch];
          end
        end
        l2sr_pkg::CODE_CONF_RSP: begin
          if (item.payload_len < l2sr_pkg::LEN_RSP_MIN) begin
            res0.outcome = l2sr_pkg::OUT_TOO_SHORT;
          end else if (!cid_hit) begin
            res0.outcome = l2sr_pkg::OUT_UNKNOWN_CID;
          end else if (item.word_two == 16'd0) begin
            // only a successful result acknowledges our request
            flags_nxt[cid_ch][l2sr_pkg::HS_OUR_ACK] = 1'b1;
          end
        end
        default: begin
          res0.outcome = l2sr_pkg::OUT_UNHANDLED;
        end
      endcase
    end

    // Both-open reflects the state after the whole command
    open_nxt       = l2sr_pkg::is_open(flags_nxt[1]) & l2sr_pkg::is_open(flags_nxt[2]);
    res0.both_open = open_nxt;
    res1.both_open = open_nxt;
    res0.last      = ~two;
    res1.last      = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < l2sr_pkg::NUM_CH; i++) begin
        rcid_r[i]  <= '0;
        flags_r[i] <= '0;
      end
      ident_r <= '0;
    end else if (fire) begin
      rcid_r  <= rcid_nxt;
      flags_r <= flags_nxt;
      ident_r <= ident_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/l2sr_out_buf.sv =====
// Result buffer: holds the current output transaction and an optional
// second one from the same command, and presents them in order.
// Depends on l2sr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module l2sr_out_buf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire l2sr_pkg::l2sr_ctl_t ctl,
  input  wire l2sr_pkg::l2sr_out_t res0,
  input  wire l2sr_pkg::l2sr_out_t res1,
  output logic                     free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output l2sr_pkg::l2sr_out_t      out_data
);

  logic                valid_r;
  logic                pend_r;
  l2sr_pkg::l2sr_out_t cur_r;
  l2sr_pkg::l2sr_out_t sec_r;

  // Room for a new command when empty or once the last result leaves this cycle
  assign free      = !valid_r || (out_ready && !pend_r);
  assign out_valid = valid_r;
  assign out_data  = cur_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= 1'b1;
      pend_r  <= ctl.two;
    end else if (valid_r && out_ready) begin
      if (pend_r) begin
        pend_r <= 1'b0;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur_r <= res0;
      sec_r <= res1;
    end else if (valid_r && out_ready && pend_r) begin
      cur_r <= sec_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/l2sr_checker.sv =====
// Port-level checker for the L2CAP signaling responder, bound to the top.
// Depends on l2sr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module l2sr_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire l2sr_pkg::l2sr_out_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A connection response is never the last result of its command
  a_conn_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_kind == l2sr_pkg::KIND_CONN_RSP |-> !out_data.last)
    else $error("connection response marked last");

  // Its configuration request follows in the next cycle
  a_conn_then_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.packet_kind == l2sr_pkg::KIND_CONN_RSP
    |=> out_valid && out_data.packet_kind == l2sr_pkg::KIND_CONF_REQ && out_data.last)
    else $error("configuration request missing after connection response");

  // Our configuration request carries a nonzero ident
  a_req_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_kind == l2sr_pkg::KIND_CONF_REQ
    |-> out_data.out_ident != 8'd0 && out_data.outcome == l2sr_pkg::OUT_HANDLED)
    else $error("bad configuration request ident");

  // Status records carry no addressing
  a_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_kind == l2sr_pkg::KIND_STATUS
    |-> out_data.out_ident == 8'd0 && out_data.dest_cid == 16'd0
        && out_data.source_cid == 16'd0 && out_data.last)
    else $error("status record carries addressing");

endmodule

bind l2cap_signaling_responder_core l2sr_checker u_l2sr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
